/* hdl/plb_pkg.sv */
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and codes for the price level book: beats, cell control,
// pending table control and the sequencer states.
// ----------------------------------------------------------------------------
package plb_pkg;

  // Command codes
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_CANCEL = 3'd1;
  localparam logic [2:0] CMD_MODIFY = 3'd2;
  localparam logic [2:0] CMD_TRADE  = 3'd3;

  // Side codes
  localparam logic [1:0] SIDE_BID  = 2'd0;
  localparam logic [1:0] SIDE_ASK  = 2'd1;
  localparam logic [1:0] SIDE_NONE = 2'd2;

  localparam int LEVEL_W = 4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  side;
    logic [31:0] price;
    logic [30:0] size;
    logic [63:0] ord_key;
    logic [31:0] sequence_req;
    logic [63:0] event_time;
  } in_beat_t;

  typedef struct packed {
    logic [63:0]        snap_time;
    logic [31:0]        snap_sequence;
    logic [LEVEL_W-1:0] level;
    logic               bid_present;
    logic [31:0]        bid_price;
    logic [31:0]        bid_size;
    logic               ask_present;
    logic [31:0]        ask_price;
    logic [31:0]        ask_size;
    logic               overflow;
    logic               last;
  } out_beat_t;

  // One price level held in a cell
  typedef struct packed {
    logic        valid;
    logic [31:0] price;
    logic [31:0] qty;
  } cell_data_t;

  typedef enum logic [1:0] {
    CPH_HOLD,
    CPH_EVAL,
    CPH_APPLY
  } cell_phase_e;

  // Broadcast to every cell of one side
  typedef struct packed {
    cell_phase_e phase;
    logic        is_add;
    logic [31:0] price;
    logic [30:0] size;
  } cell_ctl_t;

  typedef struct packed {
    logic hit_any;
    logic full;
  } side_stat_t;

  typedef struct packed {
    logic        look;
    logic        wr;
    logic        clr;
    logic [63:0] id;
    logic        ask;
    logic [63:0] ev_time;
    logic [31:0] seq;
  } pend_ctl_t;

  typedef struct packed {
    logic        hit;
    logic        room;
    logic        ask;
    logic [63:0] ev_time;
    logic [31:0] seq;
  } pend_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_EVAL,
    ST_APPLY,
    ST_SNAP
  } plb_state_e;

endpackage

/* hdl/plb_cell.sv */
// ----------------------------------------------------------------------------
// plb_cell
// One price level of a sorted side. Compares itself with the broadcast
// price, then keeps, inserts, updates, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module plb_cell import plb_pkg::*; #(
  parameter bit HIGH_FIRST = 1'b1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic       hit_any,
  input  logic       del_any,
  input  logic       full,
  input  logic       first,
  input  logic       prev_before,
  input  cell_data_t left_d,
  input  cell_data_t right_d,
  output cell_data_t cur_d,
  output logic       before_o,
  output logic       match_o,
  output logic       del_o
);

  cell_data_t data_r, data_nxt;
  logic       before_r, match_r, del_r;
  logic       better;
  logic [32:0] sum;

  assign better = HIGH_FIRST ? (data_r.price > ctl.price) : (data_r.price < ctl.price);
  assign sum    = {1'b0, data_r.qty} + {2'b0, ctl.size};

  // flags from the compare phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      before_r <= 1'b0;
      match_r  <= 1'b0;
      del_r    <= 1'b0;
    end else if (ctl.phase == CPH_EVAL) begin
      before_r <= data_r.valid && better;
      match_r  <= data_r.valid && (data_r.price == ctl.price);
      del_r    <= data_r.valid && (data_r.price == ctl.price) &&
                  ({1'b0, ctl.size} >= data_r.qty);
    end
  end

  // apply phase: insert / update / delete with neighbor shift
  always_comb begin
    data_nxt = data_r;
    if (ctl.phase == CPH_APPLY) begin
      if (ctl.is_add) begin
        if (before_r) begin
          data_nxt = data_r;
        end else if (match_r) begin
          data_nxt.qty = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end else if (!hit_any && !full) begin
          if (first || prev_before) begin
            data_nxt.valid = 1'b1;
            data_nxt.price = ctl.price;
            data_nxt.qty   = {1'b0, ctl.size};
          end else begin
            data_nxt = left_d;
          end
        end
      end else begin
        if (del_any && !before_r) begin
          data_nxt = right_d;
        end else if (match_r) begin
          data_nxt.qty = data_r.qty - {1'b0, ctl.size};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign cur_d    = data_r;
  assign before_o = before_r;
  assign match_o  = match_r;
  assign del_o    = del_r;

endmodule

/* hdl/plb_side.sv */
// ----------------------------------------------------------------------------
// plb_side
// One side of the book: a chain of cells kept sorted best first.
// ----------------------------------------------------------------------------
module plb_side import plb_pkg::*; #(
  parameter int BOOK_LEVELS = 64,
  parameter int TOP_LEVELS  = 10,
  parameter bit HIGH_FIRST  = 1'b1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  output side_stat_t stat,
  output cell_data_t top_d [TOP_LEVELS]
);

  cell_data_t             cells [BOOK_LEVELS];
  logic [BOOK_LEVELS-1:0] before_v, match_v, del_v;
  logic                   hit_any, del_any;

  // match and delete flags are registered in the cells
  assign hit_any = |match_v;
  assign del_any = |del_v;

  assign stat.hit_any = hit_any;
  assign stat.full    = cells[BOOK_LEVELS-1].valid;

  for (genvar i = 0; i < BOOK_LEVELS; i++) begin : g_cell
    cell_data_t left_d, right_d;
    logic       prev_before;
    if (i == 0) begin : g_head
      assign left_d      = '0;
      assign prev_before = 1'b0;
    end else begin : g_body
      assign left_d      = cells[i-1];
      assign prev_before = before_v[i-1];
    end
    if (i == BOOK_LEVELS - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid
      assign right_d = cells[i+1];
    end

    plb_cell #(.HIGH_FIRST(HIGH_FIRST)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .hit_any     (hit_any),
      .del_any     (del_any),
      .full        (stat.full),
      .first       (i == 0),
      .prev_before (prev_before),
      .left_d      (left_d),
      .right_d     (right_d),
      .cur_d       (cells[i]),
      .before_o    (before_v[i]),
      .match_o     (match_v[i]),
      .del_o       (del_v[i])
    );
  end

  for (genvar j = 0; j < TOP_LEVELS; j++) begin : g_top
    assign top_d[j] = cells[j];
  end

endmodule

/* hdl/plb_pend.sv */
// ----------------------------------------------------------------------------
// plb_pend
// Pending trade table: id lookup, slot choice, write and free.
// ----------------------------------------------------------------------------
module plb_pend import plb_pkg::*; #(
  parameter int PENDING_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pend_ctl_t  ctl,
  output pend_stat_t stat
);

  localparam int IW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

  logic [PENDING_ENTRIES-1:0] used_r;
  logic [63:0]                order_r [PENDING_ENTRIES];
  logic [63:0]                time_r  [PENDING_ENTRIES];
  logic [31:0]                seq_r   [PENDING_ENTRIES];
  logic                       ask_r   [PENDING_ENTRIES];

  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic          hit_c, free_c;
  logic [IW-1:0] hit_idx_c, free_idx_c, slot;

  // first matching and first free entry
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
      if (used_r[i] && (order_r[i] == ctl.id)) begin
        hit_c     = 1'b1;
        hit_idx_c = IW'(i);
      end
      if (!used_r[i]) begin
        free_c     = 1'b1;
        free_idx_c = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (ctl.look) begin
      hit_r  <= hit_c;
      free_r <= free_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.look) begin
      hit_idx_r  <= hit_idx_c;
      free_idx_r <= free_idx_c;
    end
  end

  assign slot = hit_r ? hit_idx_r : free_idx_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ctl.wr) begin
      used_r[slot] <= 1'b1;
    end else if (ctl.clr) begin
      used_r[hit_idx_r] <= 1'b0;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      order_r[slot] <= ctl.id;
      time_r[slot]  <= ctl.ev_time;
      seq_r[slot]   <= ctl.seq;
      ask_r[slot]   <= ctl.ask;
    end
  end

  assign stat.hit     = hit_r;
  assign stat.room    = hit_r | free_r;
  assign stat.ask     = ask_r[hit_idx_r];
  assign stat.ev_time = time_r[hit_idx_r];
  assign stat.seq     = seq_r[hit_idx_r];

endmodule

/* hdl/price_level_book_top10.sv */
// ----------------------------------------------------------------------------
// price_level_book_top10
// Two-sided aggregated price level book with a top-of-book snapshot.
// ----------------------------------------------------------------------------
// Each side is a chain of BOOK_LEVELS cells kept sorted best first, so the
// snapshot is read straight from the head cells. One message is handled at a
// time: after the accept come a pending lookup and a decode, then a compare
// and a shift for each book update (modify may need two updates; a side of
// none or other needs none, unless a cancel hits the pending table), then
// TOP_LEVELS snapshot beats, each taken when the output is ready. A trade or
// an ignored command ends after the decode and gives no snapshot. The
// snapshot length sets the sustained rate.
// ----------------------------------------------------------------------------
module price_level_book_top10 import plb_pkg::*; #(
  parameter int BOOK_LEVELS     = 64,
  parameter int TOP_LEVELS      = 10,
  parameter int PENDING_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int LIW = (TOP_LEVELS > 1) ? $clog2(TOP_LEVELS) : 1;

  plb_state_e         state_r, state_nxt;
  in_beat_t           item_r;
  logic               op_ask_r, op_ask_nxt;
  logic               op_add_r, op_add_nxt;
  logic [30:0]        op_size_r, op_size_nxt;
  logic               mod_r, mod_nxt;
  logic [63:0]        st_time_r, st_time_nxt;
  logic [31:0]        st_seq_r, st_seq_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               ovf_r, ovf_nxt;
  logic               side_ok;

  cell_ctl_t  ctl, bid_ctl, ask_ctl;
  side_stat_t bid_stat, ask_stat, op_stat;
  cell_data_t bid_top [TOP_LEVELS];
  cell_data_t ask_top [TOP_LEVELS];
  pend_ctl_t  p_ctl;
  pend_stat_t p_stat;
  cell_data_t bid_d, ask_d;

  assign side_ok = (item_r.side == SIDE_BID) || (item_r.side == SIDE_ASK);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovf_r   <= 1'b0;
      level_r <= '0;
      mod_r   <= 1'b0;
      op_add_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovf_r    <= ovf_nxt;
      level_r  <= level_nxt;
      mod_r    <= mod_nxt;
      op_add_r <= op_add_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    op_ask_r  <= op_ask_nxt;
    op_size_r <= op_size_nxt;
    st_time_r <= st_time_nxt;
    st_seq_r  <= st_seq_nxt;
  end

  assign op_stat = op_ask_r ? ask_stat : bid_stat;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    op_ask_nxt  = op_ask_r;
    op_add_nxt  = op_add_r;
    op_size_nxt = op_size_r;
    mod_nxt     = mod_r;
    st_time_nxt = st_time_r;
    st_seq_nxt  = st_seq_r;
    level_nxt   = level_r;
    ovf_nxt     = ovf_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctl         = '{phase: CPH_HOLD, is_add: op_add_r, price: item_r.price,
                    size: op_size_r};
    p_ctl       = '{look: 1'b0, wr: 1'b0, clr: 1'b0, id: item_r.ord_key,
                    ask: (item_r.side == SIDE_ASK), ev_time: item_r.event_time,
                    seq: item_r.sequence_req};
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        p_ctl.look = 1'b1;
        state_nxt  = ST_DECIDE;
      end
      ST_DECIDE: begin
        st_time_nxt = item_r.event_time;
        st_seq_nxt  = item_r.sequence_req;
        op_ask_nxt  = (item_r.side == SIDE_ASK);
        op_size_nxt = item_r.size;
        mod_nxt     = 1'b0;
        level_nxt   = '0;
        state_nxt   = ST_IDLE;
        case (item_r.cmd)
          CMD_ADD: begin
            op_add_nxt = 1'b1;
            state_nxt  = side_ok ? ST_EVAL : ST_SNAP;
          end
          CMD_CANCEL: begin
            op_add_nxt = 1'b0;
            if (p_stat.hit) begin
              p_ctl.clr   = 1'b1;
              op_ask_nxt  = !p_stat.ask;
              st_time_nxt = p_stat.ev_time;
              st_seq_nxt  = p_stat.seq;
              state_nxt   = ST_EVAL;
            end else begin
              state_nxt = side_ok ? ST_EVAL : ST_SNAP;
            end
          end
          CMD_MODIFY: begin
            op_add_nxt  = 1'b0;
            op_size_nxt = '0;
            mod_nxt     = 1'b1;
            state_nxt   = side_ok ? ST_EVAL : ST_SNAP;
          end
          CMD_TRADE: begin
            if (item_r.side != SIDE_NONE) begin
              if (p_stat.room) begin
                p_ctl.wr = 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_EVAL: begin
        ctl.phase = CPH_EVAL;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        ctl.phase = CPH_APPLY;
        if (op_add_r && !op_stat.hit_any && op_stat.full) begin
          ovf_nxt = 1'b1;
        end
        if (mod_r && (item_r.size != '0)) begin
          mod_nxt     = 1'b0;
          op_add_nxt  = 1'b1;
          op_size_nxt = item_r.size;
          state_nxt   = ST_EVAL;
        end else begin
          state_nxt = ST_SNAP;
        end
      end
      ST_SNAP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (level_r == LEVEL_W'(TOP_LEVELS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            level_nxt = level_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // route the broadcast to the selected side only
  always_comb begin
    bid_ctl = ctl;
    ask_ctl = ctl;
    if (op_ask_r) begin
      bid_ctl.phase = CPH_HOLD;
    end else begin
      ask_ctl.phase = CPH_HOLD;
    end
  end

  plb_side #(
    .BOOK_LEVELS (BOOK_LEVELS),
    .TOP_LEVELS  (TOP_LEVELS),
    .HIGH_FIRST  (1'b1)
  ) u_bid (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bid_ctl),
    .stat  (bid_stat),
    .top_d (bid_top)
  );

  plb_side #(
    .BOOK_LEVELS (BOOK_LEVELS),
    .TOP_LEVELS  (TOP_LEVELS),
    .HIGH_FIRST  (1'b0)
  ) u_ask (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ask_ctl),
    .stat  (ask_stat),
    .top_d (ask_top)
  );

  plb_pend #(
    .PENDING_ENTRIES (PENDING_ENTRIES)
  ) u_pend (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (p_ctl),
    .stat  (p_stat)
  );

  // snapshot beat
  assign bid_d = bid_top[level_r[LIW-1:0]];
  assign ask_d = ask_top[level_r[LIW-1:0]];

  always_comb begin
    out_data.snap_time     = st_time_r;
    out_data.snap_sequence = st_seq_r;
    out_data.level         = level_r;
    out_data.bid_present   = bid_d.valid;
    out_data.bid_price     = bid_d.valid ? bid_d.price : '0;
    out_data.bid_size      = bid_d.valid ? bid_d.qty : '0;
    out_data.ask_present   = ask_d.valid;
    out_data.ask_price     = ask_d.valid ? ask_d.price : '0;
    out_data.ask_size      = ask_d.valid ? ask_d.qty : '0;
    out_data.overflow      = ovf_r;
    out_data.last          = (level_r == LEVEL_W'(TOP_LEVELS - 1));
  end

endmodule

/* sim/price_level_book_top10_chk.sv */
// ----------------------------------------------------------------------------
// price_level_book_top10_chk
// Watches both channels of the price level book, keeps a shadow book and a
// shadow trade table, predicts each snapshot and compares it beat by beat.
// ----------------------------------------------------------------------------
module price_level_book_top10_chk import plb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        snap_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLVL  = 64;
  localparam int NTOP  = 10;
  localparam int NPEND = 16;

  // Shadow book, one array set per side (0 bid, 1 ask)
  logic [31:0] lvl_px   [2][NLVL];
  logic [31:0] lvl_qty  [2][NLVL];
  bit          lvl_live [2][NLVL];
  bit          tr_live  [NPEND];
  logic [63:0] tr_id    [NPEND];
  bit          tr_ask   [NPEND];
  logic [63:0] tr_time  [NPEND];
  logic [31:0] tr_seq   [NPEND];
  bit          ovf_flag;

  out_beat_t snap_q[$];

  function automatic int find_level(int s, logic [31:0] px);
    for (int i = 0; i < NLVL; i++)
      if (lvl_live[s][i] && lvl_px[s][i] == px) return i;
    return -1;
  endfunction

  function automatic void level_put(int s, logic [31:0] px, logic [31:0] qty);
    int i;
    logic [32:0] sum;
    i = find_level(s, px);
    if (i >= 0) begin
      sum = lvl_qty[s][i] + qty;
      lvl_qty[s][i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      return;
    end
    for (int k = 0; k < NLVL; k++)
      if (!lvl_live[s][k]) begin
        lvl_live[s][k] = 1; lvl_px[s][k] = px; lvl_qty[s][k] = qty;
        return;
      end
    ovf_flag = 1;
  endfunction

  function automatic void level_take(int s, logic [31:0] px, logic [31:0] qty);
    int i;
    i = find_level(s, px);
    if (i < 0) return;
    if (qty >= lvl_qty[s][i]) begin
      lvl_live[s][i] = 0; lvl_px[s][i] = '0; lvl_qty[s][i] = '0;
    end else begin
      lvl_qty[s][i] -= qty;
    end
  endfunction

  // Queue one full ten-level snapshot
  function automatic void push_snapshot(logic [63:0] t, logic [31:0] sq);
    out_beat_t b [NTOP];
    for (int s = 0; s < 2; s++) begin
      bit have_prev;
      logic [31:0] prev;
      have_prev = 0; prev = '0;
      for (int r = 0; r < NTOP; r++) begin
        int best;
        best = -1;
        for (int i = 0; i < NLVL; i++) begin
          if (!lvl_live[s][i]) continue;
          if (have_prev && (s == 0 ? lvl_px[s][i] >= prev : lvl_px[s][i] <= prev))
            continue;
          if (best < 0 || (s == 0 ? lvl_px[s][i] > lvl_px[s][best]
                                  : lvl_px[s][i] < lvl_px[s][best]))
            best = i;
        end
        if (s == 0) begin
          b[r].bid_present = best >= 0;
          b[r].bid_price   = best >= 0 ? lvl_px[s][best] : '0;
          b[r].bid_size    = best >= 0 ? lvl_qty[s][best] : '0;
        end else begin
          b[r].ask_present = best >= 0;
          b[r].ask_price   = best >= 0 ? lvl_px[s][best] : '0;
          b[r].ask_size    = best >= 0 ? lvl_qty[s][best] : '0;
        end
        have_prev = 1;
        prev = best >= 0 ? lvl_px[s][best] : (s == 0 ? 32'h0 : 32'hFFFF_FFFF);
      end
    end
    for (int r = 0; r < NTOP; r++) begin
      b[r].snap_time = t; b[r].snap_sequence = sq; b[r].level = r[LEVEL_W-1:0];
      b[r].overflow = ovf_flag; b[r].last = (r == NTOP - 1);
      snap_q.insert(snap_q.size(), b[r]);
    end
  endfunction

  function automatic void apply_message(in_beat_t m);
    int slot;
    case (m.cmd)
      CMD_ADD: begin
        if (m.side <= SIDE_ASK) level_put(m.side, m.price, {1'b0, m.size});
        push_snapshot(m.event_time, m.sequence_req);
      end
      CMD_CANCEL: begin
        for (int i = 0; i < NPEND; i++)
          if (tr_live[i] && tr_id[i] == m.ord_key) begin
            level_take(tr_ask[i] ? 0 : 1, m.price, {1'b0, m.size});
            tr_live[i] = 0;
            push_snapshot(tr_time[i], tr_seq[i]);
            return;
          end
        if (m.side <= SIDE_ASK) level_take(m.side, m.price, {1'b0, m.size});
        push_snapshot(m.event_time, m.sequence_req);
      end
      CMD_MODIFY: begin
        if (m.side <= SIDE_ASK) begin
          level_take(m.side, m.price, '0);
          if (m.size != 0) level_put(m.side, m.price, {1'b0, m.size});
        end
        push_snapshot(m.event_time, m.sequence_req);
      end
      CMD_TRADE: begin
        if (m.side == SIDE_NONE) return;
        slot = -1;
        for (int i = 0; i < NPEND; i++)
          if (tr_live[i] && tr_id[i] == m.ord_key) begin slot = i; break; end
        if (slot < 0)
          for (int i = 0; i < NPEND; i++)
            if (!tr_live[i]) begin slot = i; break; end
        if (slot < 0) begin
          ovf_flag = 1;
          return;
        end
        tr_live[slot] = 1; tr_id[slot] = m.ord_key; tr_ask[slot] = m.side == SIDE_ASK;
        tr_time[slot] = m.event_time; tr_seq[slot] = m.sequence_req;
      end
      default: ;
    endcase
  endfunction

  // Watch both channels; input first so a same-edge snapshot is predicted
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst_n) begin
      for (int s = 0; s < 2; s++)
        for (int i = 0; i < NLVL; i++) begin
          lvl_live[s][i] = 0; lvl_px[s][i] = '0; lvl_qty[s][i] = '0;
        end
      for (int i = 0; i < NPEND; i++) tr_live[i] = 0;
      ovf_flag = 0;
      snap_q.delete();
      fail_count = 0;
      snap_beats = 0;
    end else begin
      if (in_valid && in_ready) apply_message(in_data);
      if (out_valid && out_ready) begin
        snap_beats++;
        if (snap_q.size() == 0) begin
          $error("unexpected snapshot beat level %0d", out_data.level);
          fail_count++;
        end else begin
          e = snap_q.pop_front();
          if (out_data.snap_time !== e.snap_time) begin
            $error("snap_time exp %0h got %0h", e.snap_time, out_data.snap_time);
            fail_count++;
          end
          if (out_data.snap_sequence !== e.snap_sequence) begin
            $error("snap_sequence exp %0h got %0h", e.snap_sequence, out_data.snap_sequence);
            fail_count++;
          end
          if (out_data.level !== e.level) begin
            $error("level exp %0d got %0d", e.level, out_data.level);
            fail_count++;
          end
          if (out_data.bid_present !== e.bid_present) begin
            $error("bid_present exp %0b got %0b", e.bid_present, out_data.bid_present);
            fail_count++;
          end
          if (out_data.bid_price !== e.bid_price) begin
            $error("bid_price exp %0h got %0h", e.bid_price, out_data.bid_price);
            fail_count++;
          end
          if (out_data.bid_size !== e.bid_size) begin
            $error("bid_size exp %0h got %0h", e.bid_size, out_data.bid_size);
            fail_count++;
          end
          if (out_data.ask_present !== e.ask_present) begin
            $error("ask_present exp %0b got %0b", e.ask_present, out_data.ask_present);
            fail_count++;
          end
          if (out_data.ask_price !== e.ask_price) begin
            $error("ask_price exp %0h got %0h", e.ask_price, out_data.ask_price);
            fail_count++;
          end
          if (out_data.ask_size !== e.ask_size) begin
            $error("ask_size exp %0h got %0h", e.ask_size, out_data.ask_size);
            fail_count++;
          end
          if (out_data.overflow !== e.overflow) begin
            $error("overflow exp %0b got %0b", e.overflow, out_data.overflow);
            fail_count++;
          end
          if (out_data.last !== e.last) begin
            $error("last exp %0b got %0b", e.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic int pending_beats();
    return snap_q.size();
  endfunction

endmodule

/* sim/price_level_book_top10_tb.sv */
// ----------------------------------------------------------------------------
// price_level_book_top10_tb
// Drives book messages into the price level book under random idling and a
// long output hold-off; the checker beside the block predicts the snapshots.
// ----------------------------------------------------------------------------
module price_level_book_top10_tb;
  import plb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_FILL   = 3'd4;
  localparam logic [2:0] CMD_OTHER  = 3'd5;
  localparam logic [2:0] CMD_SPARE  = 3'd7;
  localparam logic [1:0] SIDE_OTHER = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_beat_t out_data;
  int        fail_count, snap_beats;
  int        send_idle_pct = 0, recv_idle_pct = 0;
  bit        hold_off = 0;
  int        cycle_count = 0;
  int        msg_count = 0;

  price_level_book_top10 dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  price_level_book_top10_chk chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .snap_beats
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver: random stall, or a long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Few prices so levels collide; some ids reused so trades match cancels
  logic [31:0] px_pool [8];
  logic [63:0] id_pool [24];

  // Valid drops only on an idle cycle, so back-to-back beats keep it high
  task automatic send_msg(in_beat_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
    msg_count++;
  endtask

  function automatic in_beat_t mk(logic [2:0] c, logic [1:0] s, logic [31:0] p,
                                  logic [30:0] z, logic [63:0] id);
    in_beat_t m;
    m.cmd = c; m.side = s; m.price = p; m.size = z; m.ord_key = id;
    m.sequence_req = $urandom;
    m.event_time = {$urandom, $urandom};
    return m;
  endfunction

  function automatic in_beat_t rand_msg(bit deep);
    int r;
    logic [1:0] s;
    r = $urandom_range(99);
    s = $urandom_range(99) < 90 ? 2'($urandom_range(1)) : 2'($urandom_range(3));
    if (!deep) return mk(3'($urandom_range(7)), 2'($urandom), $urandom, 31'($urandom),
                         {$urandom, $urandom});
    if (r < 35) return mk(CMD_ADD, s, px_pool[$urandom_range(7)],
                          $urandom_range(99) < 10 ? 31'h7FFF_FFFF
                                                  : 31'($urandom_range(500)),
                          id_pool[$urandom_range(23)]);
    if (r < 60) return mk(CMD_CANCEL, s, px_pool[$urandom_range(7)],
                          31'($urandom_range(400)), id_pool[$urandom_range(23)]);
    if (r < 75) return mk(CMD_MODIFY, s, px_pool[$urandom_range(7)],
                          $urandom_range(3) == 0 ? 31'h0 : 31'($urandom_range(300)),
                          id_pool[$urandom_range(23)]);
    if (r < 93) return mk(CMD_TRADE, s, $urandom, 31'($urandom),
                          id_pool[$urandom_range(23)]);
    return mk($urandom_range(1) ? CMD_FILL : 3'(CMD_OTHER + $urandom_range(2)), s,
              $urandom, 31'($urandom), {$urandom, $urandom});
  endfunction

  task automatic run_random(int n, int sidle, int ridle);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < n; i++) send_msg(rand_msg($urandom_range(99) < 92));
  endtask

  initial begin
    for (int i = 0; i < 8; i++) px_pool[i] = $urandom_range(99) < 20 ? $urandom : 1000 + i * 5;
    px_pool[0] = 32'h0;
    px_pool[7] = 32'hFFFF_FFFF;
    for (int i = 0; i < 24; i++) id_pool[i] = {$urandom, $urandom};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, every command, special cases
    send_msg(mk(CMD_ADD, SIDE_BID, 32'h0, 31'h0, 64'h0));                 // zero-size level
    send_msg(mk(CMD_ADD, SIDE_BID, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '1));
    send_msg(mk(CMD_ADD, SIDE_BID, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '1));    // sum still fits; the third add saturates
    send_msg(mk(CMD_ADD, SIDE_BID, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '1));
    send_msg(mk(CMD_ADD, SIDE_ASK, 32'h0, 31'h5, 64'h1));
    send_msg(mk(CMD_ADD, SIDE_ASK, 32'hFFFF_FFFF, 31'h7, 64'h1));
    send_msg(mk(CMD_ADD, SIDE_NONE, 32'h10, 31'h7, 64'h1));              // side none
    send_msg(mk(CMD_ADD, SIDE_OTHER, 32'h10, 31'h7, 64'h1));
    send_msg(mk(CMD_CANCEL, SIDE_ASK, 32'h1234, 31'h1, 64'h99));         // missing level
    send_msg(mk(CMD_CANCEL, SIDE_ASK, 32'h0, 31'h2, 64'h99));
    send_msg(mk(CMD_MODIFY, SIDE_BID, 32'h0, 31'h9, 64'h99));            // replace zero level, then drop it
    send_msg(mk(CMD_MODIFY, SIDE_BID, 32'h0, 31'h0, 64'h99));
    send_msg(mk(CMD_TRADE, SIDE_BID, 32'h0, 31'h0, 64'hAAAA));
    send_msg(mk(CMD_TRADE, SIDE_BID, 32'h0, 31'h0, 64'hAAAA));           // repeat id
    send_msg(mk(CMD_TRADE, SIDE_ASK, 32'h0, 31'h0, 64'hBBBB));
    send_msg(mk(CMD_TRADE, SIDE_OTHER, 32'h0, 31'h0, 64'hCCCC));
    send_msg(mk(CMD_TRADE, SIDE_NONE, 32'h0, 31'h0, 64'hDDDD));
    send_msg(mk(CMD_FILL, SIDE_BID, 32'h1, 31'h1, 64'h1));
    send_msg(mk(CMD_OTHER, SIDE_BID, 32'h1, 31'h1, 64'h1));
    send_msg(mk(CMD_SPARE, SIDE_BID, 32'h1, 31'h1, 64'h1));
    send_msg(mk(CMD_CANCEL, SIDE_BID, 32'h5, 31'h3, 64'hAAAA));          // pending, bid trade
    send_msg(mk(CMD_CANCEL, SIDE_BID, 32'hFFFF_FFFF, 31'h3, 64'hBBBB));  // pending, ask trade
    send_msg(mk(CMD_CANCEL, SIDE_BID, 32'h5, 31'h3, 64'hCCCC));

    // Fill the trade table past its size
    for (int i = 0; i < 18; i++)
      send_msg(mk(CMD_TRADE, SIDE_ASK, 32'h0, 31'h0, 64'h5000 + i));
    // Fill the bid side past its size, receiver held off meanwhile
    hold_off <= 1;
    fork
      begin
        for (int i = 0; i < 66; i++)
          send_msg(mk(CMD_ADD, SIDE_BID, 32'h100 + i, 31'h1, 64'h0));
      end
      begin
        repeat (400) @(posedge clk);
        hold_off <= 0;
      end
    join
    for (int i = 0; i < 18; i++)
      send_msg(mk(CMD_CANCEL, SIDE_BID, 32'h0, 31'h0, 64'h5000 + i));
    for (int i = 0; i < 66; i++)
      send_msg(mk(CMD_CANCEL, SIDE_BID, 32'h100 + i, 31'h7FFF_FFFF, 64'h0));

    run_random(45, 36, 48);
    run_random(45, 48, 36);
    run_random(30, 0, 0);
    in_valid <= 0;

    wait (chk.pending_beats() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d messages and checked %0d snapshot beats,", msg_count, snap_beats);
    $display("including saturation, pending cancels and both table overflows.");
    if (fail_count == 0 && chk.pending_beats() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* price_level_book_top10.f */
hdl/plb_pkg.sv
hdl/plb_cell.sv
hdl/plb_side.sv
hdl/plb_pend.sv
hdl/price_level_book_top10.sv
sim/price_level_book_top10_chk.sv
sim/price_level_book_top10_tb.sv
